// ===== rtl/core/rxle_pkg.sv =====
// Shared types, constants and character decoding for the receive line editor.
package rxle_pkg;

  localparam int DEPTH = 256;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int BYTE_W = 8;
  localparam int FILL_W = 9;

  localparam logic [BYTE_W-1:0] CH_HELP      = 8'd63;
  localparam logic [BYTE_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [BYTE_W-1:0] CH_ESCAPE    = 8'd27;
  localparam logic [BYTE_W-1:0] CH_DOLLAR    = 8'd36;
  localparam logic [BYTE_W-1:0] CH_CR        = 8'd13;
  localparam logic [BYTE_W-1:0] CH_TERM      = 8'd0;

  localparam logic MODE_RX  = 1'b0;
  localparam logic MODE_POP = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [BYTE_W-1:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              data_valid;
    logic              buffer_empty;
    logic              overflow;
    logic              line_ready;
    logic              help_request;
    logic [FILL_W-1:0] fill_level;
  } result_t;

  typedef enum logic [2:0] {
    CLS_HELP,
    CLS_BACKSPACE,
    CLS_ESCAPE,
    CLS_DOLLAR,
    CLS_CR,
    CLS_OTHER
  } char_class_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_TERM,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic load;
    logic pop;
    logic cap_data;
    logic help;
    logic backspace;
    logic escape;
    logic store;
    logic term;
  } ctrl_cmd_t;

  typedef struct packed {
    logic        is_pop;
    logic        empty;
    char_class_t cls;
  } dp_status_t;

  function automatic char_class_t classify(input logic [BYTE_W-1:0] ch);
    char_class_t cls;
    case (ch)
      CH_HELP:      cls = CLS_HELP;
      CH_BACKSPACE: cls = CLS_BACKSPACE;
      CH_ESCAPE:    cls = CLS_ESCAPE;
      CH_DOLLAR:    cls = CLS_DOLLAR;
      CH_CR:        cls = CLS_CR;
      default:      cls = CLS_OTHER;
    endcase
    return cls;
  endfunction

endpackage

// ===== rtl/core/rxle_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
module rxle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/rxle_dp.sv =====
// Datapath of the receive line editor: pointers, fill count, line store and result flags.
module rxle_dp (
  input  logic                clk,
  input  logic                rst,
  input  rxle_pkg::item_t     item,
  input  rxle_pkg::ctrl_cmd_t cmd,
  output rxle_pkg::dp_status_t status,
  output rxle_pkg::result_t   result
);
  import rxle_pkg::*;

  item_t             item_q;
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic [BYTE_W-1:0] data_byte;
  logic              data_valid;
  logic              buffer_empty;
  logic              overflow;
  logic              line_ready;
  logic              help_request;

  logic              cnt_zero;
  logic              full;
  logic              ram_we;
  logic              ram_re;
  logic [BYTE_W-1:0] ram_wdata;
  logic [BYTE_W-1:0] ram_rdata;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_W'(DEPTH - 1) : p - PTR_W'(1);
  endfunction

  assign cnt_zero  = (count == '0);
  assign full      = (count == CNT_W'(DEPTH));
  assign ram_we    = (cmd.store || cmd.term) && !full;
  assign ram_wdata = cmd.term ? CH_TERM : item_q.rx_byte;
  assign ram_re    = cmd.pop && !cnt_zero;

  rxle_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(DEPTH)
  ) u_line_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wr_ptr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(rd_ptr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else if (ram_re) begin
      rd_ptr <= ptr_inc(rd_ptr);
      count  <= count - CNT_W'(1);
    end else if (ram_we) begin
      wr_ptr <= ptr_inc(wr_ptr);
      count  <= count + CNT_W'(1);
    end else if (cmd.backspace && !cnt_zero) begin
      wr_ptr <= ptr_dec(wr_ptr);
      count  <= count - CNT_W'(1);
    end else if (cmd.escape) begin
      rd_ptr <= wr_ptr;
      count  <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_q       <= item;
      data_byte    <= '0;
      data_valid   <= 1'b0;
      buffer_empty <= 1'b0;
      overflow     <= 1'b0;
      line_ready   <= 1'b0;
      help_request <= 1'b0;
    end else begin
      if (cmd.pop) begin
        data_valid   <= !cnt_zero;
        buffer_empty <= cnt_zero;
      end
      if (cmd.cap_data) begin
        data_byte <= ram_rdata;
      end
      if (cmd.help) begin
        help_request <= 1'b1;
      end
      if ((cmd.store || cmd.term) && full) begin
        overflow <= 1'b1;
      end
      if (cmd.term) begin
        line_ready <= 1'b1;
      end
    end
  end

  assign status.is_pop = (item_q.mode == MODE_POP);
  assign status.empty  = cnt_zero;
  assign status.cls    = classify(item_q.rx_byte);

  assign result.data_byte    = data_byte;
  assign result.data_valid   = data_valid;
  assign result.buffer_empty = buffer_empty;
  assign result.overflow     = overflow;
  assign result.line_ready   = line_ready;
  assign result.help_request = help_request;
  assign result.fill_level   = FILL_W'(count);

endmodule

// ===== rtl/core/rxle_ctrl.sv =====
// Controller state machine that sequences one command through the datapath.
module rxle_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  rxle_pkg::dp_status_t status,
  output rxle_pkg::ctrl_cmd_t  cmd,
  output logic                 busy,
  output logic                 done
);
  import rxle_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    done       = 1'b0;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_RESP;
        if (status.is_pop) begin
          cmd.pop = 1'b1;
          if (!status.empty) begin
            state_next = ST_READ;
          end
        end else begin
          case (status.cls)
            CLS_HELP:      cmd.help = 1'b1;
            CLS_BACKSPACE: cmd.backspace = 1'b1;
            CLS_ESCAPE:    cmd.escape = 1'b1;
            CLS_DOLLAR:    cmd = '0;
            CLS_CR: begin
              cmd.store  = 1'b1;
              state_next = ST_TERM;
            end
            default:       cmd.store = 1'b1;
          endcase
        end
      end
      ST_READ: begin
        cmd.cap_data = 1'b1;
        state_next   = ST_RESP;
      end
      ST_TERM: begin
        cmd.term   = 1'b1;
        state_next = ST_RESP;
      end
      ST_RESP: begin
        done       = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/rx_line_edit_fifo.sv =====
// Top level of the receive line editor with its circular line store.
//
// A command is taken when start is high while busy is low, and its single result
// appears on result for exactly one cycle with done high; the receiver cannot
// stall it, so it must sample result whenever done is high. A received byte passes
// from the accepting cycle in ST_IDLE through ST_EXEC to ST_RESP, where done is
// high. A carriage return or a pop of a stored byte also passes through a further
// state before ST_RESP: the carriage return writes its terminator through the one
// write port of the line store in ST_TERM, and a pop waits in ST_READ for the
// registered read of that store. busy falls in the cycle after done, so a new
// command is taken only once the last has returned its result. Entries of the line
// store are not cleared at reset; only entries covered by the fill count are read.
module rx_line_edit_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  rxle_pkg::item_t   item,
  output logic              busy,
  output logic              done,
  output rxle_pkg::result_t result
);
  import rxle_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  rxle_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .status(status),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  rxle_dp u_dp (
    .clk   (clk),
    .rst   (rst),
    .item  (item),
    .cmd   (cmd),
    .status(status),
    .result(result)
  );

`ifndef SYNTHESIS
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

  a_pop_exclusive: assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.data_valid && result.buffer_empty))
    else $error("pop reported both data and empty");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.fill_level <= FILL_W'(DEPTH)))
    else $error("fill level beyond depth");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepting a beat");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the receive line editor with its line store.
module testbench;
  import rxle_pkg::*;

  localparam int WATCHDOG_CYCLES = 1000;
  localparam int RANDOM_BEATS = 60;

  typedef enum int {ROW_ITEM, ROW_FILL, ROW_DRAIN} row_kind_t;

  typedef struct {
    row_kind_t kind;
    item_t     cmd;
    bit        typed;
    result_t   want;
    int        target;
  } step_row_t;

  logic    clk;
  logic    rst;
  logic    start;
  item_t   item;
  logic    busy;
  logic    done;
  result_t result;

  rx_line_edit_fifo DUT (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  logic [BYTE_W-1:0] line_copy [DEPTH];
  int unsigned wr_idx = 0;
  int unsigned rd_idx = 0;
  int unsigned fill_cnt = 0;

  result_t pending_results[$];
  step_row_t directed_steps[$];
  int errors = 0;
  int n_items = 0;
  int n_results = 0;
  int n_overflows = 0;
  int n_lines = 0;
  int peak_fill = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic bit keep_byte(logic [BYTE_W-1:0] b);
    if (fill_cnt >= DEPTH) return 1'b1;
    line_copy[wr_idx] = b;
    wr_idx = (wr_idx + 1) % DEPTH;
    fill_cnt++;
    return 1'b0;
  endfunction

  function automatic result_t predict_edit(item_t it);
    result_t r;
    r = '0;
    if (it.mode == MODE_POP) begin
      if (fill_cnt == 0) begin
        r.buffer_empty = 1'b1;
      end else begin
        r.data_byte = line_copy[rd_idx];
        r.data_valid = 1'b1;
        rd_idx = (rd_idx + 1) % DEPTH;
        fill_cnt--;
      end
    end else begin
      case (it.rx_byte)
        CH_HELP: r.help_request = 1'b1;
        CH_BACKSPACE: begin
          if (fill_cnt > 0) begin
            wr_idx = (wr_idx + DEPTH - 1) % DEPTH;
            fill_cnt--;
          end
        end
        CH_ESCAPE: begin
          rd_idx = wr_idx;
          fill_cnt = 0;
        end
        CH_DOLLAR: ;
        default: begin
          if (keep_byte(it.rx_byte)) r.overflow = 1'b1;
          if (it.rx_byte == CH_CR) begin
            if (keep_byte(CH_TERM)) r.overflow = 1'b1;
            r.line_ready = 1'b1;
          end
        end
      endcase
    end
    r.fill_level = FILL_W'(fill_cnt);
    return r;
  endfunction

  function automatic result_t res(logic [BYTE_W-1:0] d, bit v, bit e, bit o, bit l, bit h,
                                  int f);
    result_t r;
    r.data_byte = d;
    r.data_valid = v;
    r.buffer_empty = e;
    r.overflow = o;
    r.line_ready = l;
    r.help_request = h;
    r.fill_level = FILL_W'(f);
    return r;
  endfunction

  function automatic item_t rx(logic [BYTE_W-1:0] b);
    item_t it;
    it.mode = MODE_RX;
    it.rx_byte = b;
    return it;
  endfunction

  function automatic item_t pop_cmd(logic [BYTE_W-1:0] b);
    item_t it;
    it.mode = MODE_POP;
    it.rx_byte = b;
    return it;
  endfunction

  function automatic step_row_t row(row_kind_t kind, item_t c, bit typed, result_t w,
                                    int target);
    step_row_t s;
    s.kind = kind;
    s.cmd = c;
    s.typed = typed;
    s.want = w;
    s.target = target;
    return s;
  endfunction

  function automatic bit is_control(logic [BYTE_W-1:0] b);
    return b == CH_HELP || b == CH_BACKSPACE || b == CH_ESCAPE || b == CH_DOLLAR ||
           b == CH_CR;
  endfunction

  function automatic logic [BYTE_W-1:0] plain_byte();
    logic [BYTE_W-1:0] b;
    do b = BYTE_W'($urandom_range(0, 255)); while (is_control(b));
    return b;
  endfunction

  function automatic logic [BYTE_W-1:0] random_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return CH_HELP;
    if (r < 8) return CH_BACKSPACE;
    if (r < 9) return CH_ESCAPE;
    if (r < 11) return CH_DOLLAR;
    if (r < 16) return CH_CR;
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  function automatic int pick_gap(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_cmd(item_t it, int gap, bit typed = 1'b0, result_t want = '0);
    result_t exp_r;
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    item <= it;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    exp_r = predict_edit(it);
    pending_results.push_back(typed ? want : exp_r);
    n_items++;
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    result_t w;
    if (!rst && done) begin
      n_results++;
      if (result.overflow === 1'b1) n_overflows++;
      if (result.line_ready === 1'b1) n_lines++;
      if (int'(result.fill_level) > peak_fill) peak_fill = int'(result.fill_level);
      if (pending_results.size() == 0) begin
        $error("result beat with no command outstanding");
        errors++;
      end else begin
        w = pending_results.pop_front();
        check_field("data_byte", w.data_byte, result.data_byte);
        check_field("data_valid", w.data_valid, result.data_valid);
        check_field("buffer_empty", w.buffer_empty, result.buffer_empty);
        check_field("overflow", w.overflow, result.overflow);
        check_field("line_ready", w.line_ready, result.line_ready);
        check_field("help_request", w.help_request, result.help_request);
        check_field("fill_level", w.fill_level, result.fill_level);
      end
    end
  end

  initial begin
    int idle = 0;
    while (idle < WATCHDOG_CYCLES) begin
      @(posedge clk);
      if (rst || (start && !busy) || done) idle = 0;
      else idle++;
    end
    $display("[rx_line_edit_fifo] ERROR");
    $finish;
  end

  initial begin
    int n_rand;
    int seg_len;
    int pop_pct;
    bit quiet;
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    n_rand = 0;

    directed_steps.push_back(row(ROW_ITEM, pop_cmd(8'hFF), 1, res(0, 0, 1, 0, 0, 0, 0), 0));
    directed_steps.push_back(row(ROW_ITEM, rx(CH_BACKSPACE), 1, res(0, 0, 0, 0, 0, 0, 0), 0));
    directed_steps.push_back(row(ROW_ITEM, rx(CH_HELP), 1, res(0, 0, 0, 0, 0, 1, 0), 0));
    directed_steps.push_back(row(ROW_ITEM, rx(CH_DOLLAR), 1, res(0, 0, 0, 0, 0, 0, 0), 0));
    directed_steps.push_back(row(ROW_ITEM, rx(8'h00), 1, res(0, 0, 0, 0, 0, 0, 1), 0));
    directed_steps.push_back(row(ROW_ITEM, rx(8'hFF), 1, res(0, 0, 0, 0, 0, 0, 2), 0));
    directed_steps.push_back(row(ROW_ITEM, rx(CH_CR), 1, res(0, 0, 0, 0, 1, 0, 4), 0));
    directed_steps.push_back(row(ROW_ITEM, rx(CH_BACKSPACE), 1, res(0, 0, 0, 0, 0, 0, 3), 0));
    directed_steps.push_back(row(ROW_ITEM, pop_cmd(8'h00), 1, res(8'h00, 1, 0, 0, 0, 0, 2), 0));
    directed_steps.push_back(row(ROW_ITEM, pop_cmd(8'h00), 1, res(8'hFF, 1, 0, 0, 0, 0, 1), 0));
    directed_steps.push_back(row(ROW_ITEM, pop_cmd(8'h00), 1, res(CH_CR, 1, 0, 0, 0, 0, 0), 0));
    directed_steps.push_back(row(ROW_ITEM, rx(8'h41), 1, res(0, 0, 0, 0, 0, 0, 1), 0));
    directed_steps.push_back(row(ROW_ITEM, rx(CH_ESCAPE), 1, res(0, 0, 0, 0, 0, 0, 0), 0));
    directed_steps.push_back(row(ROW_ITEM, pop_cmd(8'h00), 1, res(0, 0, 1, 0, 0, 0, 0), 0));
    directed_steps.push_back(row(ROW_FILL, '0, 0, '0, DEPTH - 1));
    directed_steps.push_back(row(ROW_ITEM, rx(CH_CR), 1, res(0, 0, 0, 1, 1, 0, DEPTH), 0));
    directed_steps.push_back(row(ROW_ITEM, rx(8'h80), 1, res(0, 0, 0, 1, 0, 0, DEPTH), 0));
    directed_steps.push_back(row(ROW_ITEM, rx(CH_CR), 1, res(0, 0, 0, 1, 1, 0, DEPTH), 0));
    directed_steps.push_back(row(ROW_ITEM, rx(CH_HELP), 1, res(0, 0, 0, 0, 0, 1, DEPTH), 0));
    directed_steps.push_back(row(ROW_ITEM, rx(CH_BACKSPACE), 1,
                                 res(0, 0, 0, 0, 0, 0, DEPTH - 1), 0));
    directed_steps.push_back(row(ROW_ITEM, rx(8'h7E), 0, '0, 0));
    directed_steps.push_back(row(ROW_DRAIN, '0, 0, '0, 0));
    directed_steps.push_back(row(ROW_ITEM, pop_cmd(8'h5A), 1, res(0, 0, 1, 0, 0, 0, 0), 0));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_steps[i]) begin
      case (directed_steps[i].kind)
        ROW_ITEM: send_cmd(directed_steps[i].cmd, pick_gap(0), directed_steps[i].typed,
                           directed_steps[i].want);
        ROW_FILL: while (fill_cnt < directed_steps[i].target) send_cmd(rx(plain_byte()),
                                                                       pick_gap(1));
        ROW_DRAIN: while (fill_cnt > 0) send_cmd(pop_cmd(BYTE_W'($urandom_range(0, 255))),
                                                 pick_gap($urandom_range(0, 1)));
      endcase
    end

    // Hold the sender off until the editor has returned every result.
    wait_for_results();

    while (n_rand < RANDOM_BEATS) begin
      seg_len = $urandom_range(20, 80);
      case ($urandom_range(0, 2))
        0: pop_pct = 10;
        1: pop_pct = 45;
        default: pop_pct = 80;
      endcase
      quiet = ($urandom_range(0, 3) == 0);
      repeat (seg_len) begin
        if ($urandom_range(0, 99) < pop_pct)
          send_cmd(pop_cmd(BYTE_W'($urandom_range(0, 255))), pick_gap(quiet));
        else
          send_cmd(rx(random_char()), pick_gap(quiet));
        n_rand++;
      end
      if ($urandom_range(0, 2) == 0) wait_for_results();
    end

    wait_for_results();
    repeat (10) @(posedge clk);

    $display("Sent %0d commands and checked %0d results: %0d overflows, %0d lines, ",
             n_items, n_results, n_overflows, n_lines);
    $display("peak fill %0d of %0d entries.", peak_fill, DEPTH);
    if (errors == 0) begin
      $display("[rx_line_edit_fifo] OK");
    end else begin
      $display("[rx_line_edit_fifo] ERROR");
    end
    $finish;
  end

endmodule
